### rtl/acrf_pkg.sv
// shared constants and byte functions for the ascii crc response framer
package acrf_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CrcW     = 16;
  localparam int unsigned CfgAddrW = 2;

  localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;
  localparam logic [CrcW-1:0] CrcPoly = 16'h1021;

  // configuration register indexes
  localparam logic [CfgAddrW-1:0] RegHeader  = 2'd0;
  localparam logic [CfgAddrW-1:0] RegStation = 2'd1;
  localparam logic [CfgAddrW-1:0] RegTrailer = 2'd2;

  // byte positions within the output sequence of one item
  localparam int unsigned NumSteps = 9;
  localparam int unsigned StepW    = 4;
  localparam logic [StepW-1:0] StepHeader  = 4'd0;
  localparam logic [StepW-1:0] StepStation = 4'd1;
  localparam logic [StepW-1:0] StepCmd     = 4'd2;
  localparam logic [StepW-1:0] StepPay     = 4'd3;
  localparam logic [StepW-1:0] StepDig3    = 4'd4;
  localparam logic [StepW-1:0] StepDig2    = 4'd5;
  localparam logic [StepW-1:0] StepDig1    = 4'd6;
  localparam logic [StepW-1:0] StepDig0    = 4'd7;
  localparam logic [StepW-1:0] StepTrailer = 4'd8;

  // crc-16/ccitt-false over one byte, msb first
  function automatic logic [CrcW-1:0] crc_feed(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < ByteW; k++) begin
      if (c[CrcW-1]) begin
        c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[CrcW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

  // uppercase ascii hex digit
  function automatic logic [ByteW-1:0] hex_char(input logic [3:0] n);
    logic [ByteW-1:0] r;
    if (n <= 4'd9) begin
      r = 8'h30 + {4'h0, n};
    end else begin
      r = 8'h41 + {4'h0, n - 4'hA};
    end
    return r;
  endfunction

endpackage

### rtl/ascii_crc_response_framer.sv
// top level of the ascii crc response framer
//
// Builds reply frames one byte per output transfer. Input channel in_valid_i /
// in_ready_o carries one item (command code, payload byte, has_payload,
// frame_last). The first item of a frame sends header, station id and command,
// then its payload byte if present; later items send only their payload byte.
// The closing item adds four uppercase hex digits of the crc-16/ccitt-false
// over all bytes sent in the frame, then the trailer byte (frame_done_o set).
// run_last_o marks the final byte caused by each item.
// Configuration: cfg_we_i writes header (0), station id (1), trailer (2);
// other indexes are ignored. Write only while the block is idle.
// Flow: the first byte of an accepted item is loaded from the item register
// into the output register once that register is free. An item occupies the
// item register until it has emitted its last byte, so middle items with a
// payload go at one per cycle while the receiver does not stall; this is set
// by the single output byte lane. The next item is taken at the edge where the
// current one emits its last byte into the output register.
// Reset clears the frame state, the crc to 0xFFFF, the configuration registers
// to zero and drops both valid flags. When the receiver stalls, the output register holds
// its byte and the item register stops advancing.
module ascii_crc_response_framer
  import acrf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [ByteW-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ByteW-1:0]    command_code_i,
  input  logic [ByteW-1:0]    payload_byte_i,
  input  logic                has_payload_i,
  input  logic                frame_last_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ByteW-1:0]    out_byte_o,
  output logic                frame_done_o,
  output logic                run_last_o
);

  logic [ByteW-1:0] header_q, station_q, trailer_q;

  logic             item_valid_q;
  logic [ByteW-1:0] item_cmd_q, item_pay_q;
  logic             item_has_pay_q, item_last_q;
  logic [StepW-1:0] step_q, step_d;

  logic            inside_q, inside_d;
  logic [CrcW-1:0] crc_q, crc_d;

  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q, out_byte_d;
  logic             frame_done_q, run_last_q;

  logic [NumSteps-1:0] active, pending;
  logic                pend_found, rest_any;
  logic [StepW-1:0]    sel_idx;
  logic                out_free, emit_en, finish, in_xfer;

  always_comb begin
    active = '0;
    active[StepHeader]  = !inside_q;
    active[StepStation] = !inside_q;
    active[StepCmd]     = !inside_q;
    active[StepPay]     = item_has_pay_q;
    active[StepDig3]    = item_last_q;
    active[StepDig2]    = item_last_q;
    active[StepDig1]    = item_last_q;
    active[StepDig0]    = item_last_q;
    active[StepTrailer] = item_last_q;
    for (int i = 0; i < NumSteps; i++) begin
      pending[i] = active[i] && (StepW'(i) >= step_q);
    end
  end

  // pick the lowest pending step and see whether any remain after it
  always_comb begin
    pend_found = 1'b0;
    rest_any   = 1'b0;
    sel_idx    = '0;
    for (int i = 0; i < NumSteps; i++) begin
      if (pending[i]) begin
        if (pend_found) begin
          rest_any = 1'b1;
        end else begin
          pend_found = 1'b1;
          sel_idx    = StepW'(i);
        end
      end
    end
  end

  always_comb begin
    unique case (sel_idx)
      StepHeader:  out_byte_d = header_q;
      StepStation: out_byte_d = station_q;
      StepCmd:     out_byte_d = item_cmd_q;
      StepPay:     out_byte_d = item_pay_q;
      StepDig3:    out_byte_d = hex_char(crc_q[15:12]);
      StepDig2:    out_byte_d = hex_char(crc_q[11:8]);
      StepDig1:    out_byte_d = hex_char(crc_q[7:4]);
      StepDig0:    out_byte_d = hex_char(crc_q[3:0]);
      StepTrailer: out_byte_d = trailer_q;
      default:     out_byte_d = '0;
    endcase
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign emit_en    = item_valid_q && pend_found && out_free;
  // an item with nothing left to send retires without touching the output
  assign finish     = item_valid_q && (!pend_found || (emit_en && !rest_any));
  assign in_ready_o = !item_valid_q || finish;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    crc_d    = crc_q;
    inside_d = inside_q;
    step_d   = step_q;
    if (emit_en) begin
      step_d = sel_idx + StepW'(1);
      if (sel_idx <= StepPay) begin
        crc_d = crc_feed(crc_q, out_byte_d);
      end
    end
    if (finish) begin
      step_d   = '0;
      inside_d = !item_last_q;
      if (item_last_q) begin
        crc_d = CrcInit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q     <= '0;
      station_q    <= '0;
      trailer_q    <= '0;
      item_valid_q <= 1'b0;
      step_q       <= '0;
      inside_q     <= 1'b0;
      crc_q        <= CrcInit;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          RegHeader:  header_q  <= cfg_wdata_i;
          RegStation: station_q <= cfg_wdata_i;
          RegTrailer: trailer_q <= cfg_wdata_i;
          default:    ;
        endcase
      end
      step_q   <= step_d;
      inside_q <= inside_d;
      crc_q    <= crc_d;
      if (in_xfer) begin
        item_valid_q <= 1'b1;
      end else if (finish) begin
        item_valid_q <= 1'b0;
      end
      if (emit_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item payload and output byte registers, not reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_cmd_q     <= command_code_i;
      item_pay_q     <= payload_byte_i;
      item_has_pay_q <= has_payload_i;
      item_last_q    <= frame_last_i;
    end
    if (emit_en) begin
      out_byte_q   <= out_byte_d;
      frame_done_q <= (sel_idx == StepTrailer);
      run_last_q   <= !rest_any;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign frame_done_o = frame_done_q;
  assign run_last_o   = run_last_q;

endmodule

### rtl/acrf_checker.sv
// port-level checker for the ascii crc response framer, bound to the top level
module acrf_checker
  import acrf_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [ByteW-1:0] out_byte_o,
  input logic             frame_done_o,
  input logic             run_last_o
);

  // the trailer is always the final byte of its item
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> run_last_o)
    else $error("frame_done without run_last");

  // a stalled output byte holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(frame_done_o) && $stable(run_last_o))
    else $error("output changed while stalled");

  // nothing is offered while in reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind ascii_crc_response_framer acrf_checker u_acrf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_byte_o   (out_byte_o),
  .frame_done_o (frame_done_o),
  .run_last_o   (run_last_o)
);
